@@ rtl/lensd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lensd_pkg
// Shared constants, types and codes for the lens distortion remap block.
// ----------------------------------------------------------------------------
package lensd_pkg;

  // Frame geometry and coefficient format
  localparam int ROWS           = 60;
  localparam int COLS           = 80;
  localparam int COEF_FRAC_BITS = 24;

  // Field widths
  localparam int ROW_W  = 6;
  localparam int COL_W  = 7;
  localparam int PIX_W  = 8;
  localparam int GAIN_W = 16;

  // Datapath widths: centred coordinates, squares, gain products, factor,
  // scaled products, mapped coordinates
  localparam int X_W   = ROW_W + 1;
  localparam int Y_W   = COL_W + 1;
  localparam int SQX_W = 2 * X_W;
  localparam int SQY_W = 2 * Y_W;
  localparam int GX_W  = GAIN_W + SQX_W;
  localparam int GY_W  = GAIN_W + SQY_W;
  localparam int F_W   = ((GX_W > GY_W) ? GX_W : GY_W) + 2;
  localparam int PX_W  = X_W + F_W;
  localparam int PY_W  = Y_W + F_W;
  localparam int CRD_W = PY_W - COEF_FRAC_BITS + 1;

  // Frame store addressing
  localparam int FRAME_DEPTH = ROWS * COLS;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int RIDX_W      = $clog2(ROWS);
  localparam int CIDX_W      = $clog2(COLS);

  // Stream widths, rounded up to whole bytes
  localparam int S_TDATA_W = ((ROW_W + COL_W + PIX_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((PIX_W + 1 + 7) / 8) * 8;

  // Configuration registers
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_ROWS = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_COLS = 1'b1;
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = GAIN_W'(-1007);

  // Transaction kind carried on tuser
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_READ  = 1'b1
  } kind_t;

  // Mapped item handed from the coordinate pipeline to the frame store
  typedef struct packed {
    kind_t                    kind;
    logic signed [CRD_W-1:0]  srow;
    logic signed [CRD_W-1:0]  scol;
    logic [PIX_W-1:0]         pixel;
  } map_item_t;

endpackage

@@ rtl/lensd_mapper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lensd_mapper
// Six-stage coordinate pipeline: centring, squares, gain products, radial
// factor, scaling, rounding and un-centring. Writes pass through unchanged.
// ----------------------------------------------------------------------------
module lensd_mapper (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  lensd_pkg::kind_t                       in_kind,
  input  logic [lensd_pkg::ROW_W-1:0]            in_row,
  input  logic [lensd_pkg::COL_W-1:0]            in_col,
  input  logic [lensd_pkg::PIX_W-1:0]            in_pixel,
  input  logic signed [lensd_pkg::GAIN_W-1:0]    gain_rows,
  input  logic signed [lensd_pkg::GAIN_W-1:0]    gain_cols,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output lensd_pkg::map_item_t                   out_item
);

  localparam int NSTG = 6;
  localparam logic signed [lensd_pkg::F_W-1:0] F_ONE =
    lensd_pkg::F_W'(1) << lensd_pkg::COEF_FRAC_BITS;
  localparam logic signed [lensd_pkg::PY_W-1:0] RND_HALF =
    lensd_pkg::PY_W'(1) << (lensd_pkg::COEF_FRAC_BITS - 1);

  // Stage valids and per-stage enables
  logic [NSTG:1] vld;
  logic [NSTG:1] en;

  // Payload carried along the stages; row and col stop at stage 5
  lensd_pkg::kind_t                 kind   [NSTG:1];
  logic [lensd_pkg::ROW_W-1:0]      row    [NSTG-1:1];
  logic [lensd_pkg::COL_W-1:0]      col    [NSTG-1:1];
  logic [lensd_pkg::PIX_W-1:0]      pixel  [NSTG:1];

  // Arithmetic registers
  logic signed [lensd_pkg::X_W-1:0]   x1, x2r, x3, x4;
  logic signed [lensd_pkg::Y_W-1:0]   y1, y2r, y3, y4;
  logic signed [lensd_pkg::SQX_W-1:0] sqx;
  logic signed [lensd_pkg::SQY_W-1:0] sqy;
  logic signed [lensd_pkg::GX_W-1:0]  gx;
  logic signed [lensd_pkg::GY_W-1:0]  gy;
  logic signed [lensd_pkg::F_W-1:0]   fac;
  logic signed [lensd_pkg::PX_W-1:0]  px;
  logic signed [lensd_pkg::PY_W-1:0]  py;
  logic signed [lensd_pkg::CRD_W-1:0] srow, scol;

  // Combinational helpers
  logic signed [lensd_pkg::X_W-1:0]   x_next;
  logic signed [lensd_pkg::Y_W-1:0]   y_next;
  logic signed [lensd_pkg::SQX_W-1:0] sqx_next;
  logic signed [lensd_pkg::SQY_W-1:0] sqy_next;
  logic signed [lensd_pkg::GX_W-1:0]  gx_next;
  logic signed [lensd_pkg::GY_W-1:0]  gy_next;
  logic signed [lensd_pkg::F_W-1:0]   fac_next;
  logic signed [lensd_pkg::PX_W-1:0]  px_next;
  logic signed [lensd_pkg::PY_W-1:0]  py_next;
  logic signed [lensd_pkg::PY_W-1:0]  rsum_x, rsum_y;
  logic signed [lensd_pkg::CRD_W-1:0] qx, qy;
  logic signed [lensd_pkg::CRD_W-1:0] srow_next, scol_next;

  // Stall chain: a stage moves when it is empty or the next one moves
  always_comb begin
    en[NSTG] = !vld[NSTG] || out_ready;
    for (int i = NSTG - 1; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in_valid;
      for (int i = 2; i <= NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Stage 1: centre the coordinates
  assign x_next = lensd_pkg::X_W'(in_row) - lensd_pkg::X_W'(lensd_pkg::ROWS / 2);
  assign y_next = lensd_pkg::Y_W'(in_col) - lensd_pkg::Y_W'(lensd_pkg::COLS / 2);

  // Stage 2: squares
  assign sqx_next = x1 * x1;
  assign sqy_next = y1 * y1;

  // Stage 3: gain products
  assign gx_next = gain_rows * sqx;
  assign gy_next = gain_cols * sqy;

  // Stage 4: radial factor
  assign fac_next = F_ONE + gx + gy;

  // Stage 5: scale the centred coordinates
  assign px_next = x4 * fac;
  assign py_next = y4 * fac;

  // Stage 6: round half away from zero (negative values take one less),
  // then remove the centring; writes keep their own coordinates
  always_comb begin
    rsum_x = lensd_pkg::PY_W'(px) + RND_HALF - lensd_pkg::PY_W'(px[lensd_pkg::PX_W-1]);
    rsum_y = py + RND_HALF - lensd_pkg::PY_W'(py[lensd_pkg::PY_W-1]);
    qx     = lensd_pkg::CRD_W'(rsum_x >>> lensd_pkg::COEF_FRAC_BITS);
    qy     = lensd_pkg::CRD_W'(rsum_y >>> lensd_pkg::COEF_FRAC_BITS);
    if (kind[5] == lensd_pkg::KIND_READ) begin
      srow_next = qx + lensd_pkg::CRD_W'(lensd_pkg::ROWS / 2);
      scol_next = qy + lensd_pkg::CRD_W'(lensd_pkg::COLS / 2);
    end else begin
      srow_next = lensd_pkg::CRD_W'(row[5]);
      scol_next = lensd_pkg::CRD_W'(col[5]);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en[1]) begin
      kind[1]  <= in_kind;
      row[1]   <= in_row;
      col[1]   <= in_col;
      pixel[1] <= in_pixel;
      x1       <= x_next;
      y1       <= y_next;
    end
    if (en[2]) begin
      kind[2]  <= kind[1];
      row[2]   <= row[1];
      col[2]   <= col[1];
      pixel[2] <= pixel[1];
      x2r      <= x1;
      y2r      <= y1;
      sqx      <= sqx_next;
      sqy      <= sqy_next;
    end
    if (en[3]) begin
      kind[3]  <= kind[2];
      row[3]   <= row[2];
      col[3]   <= col[2];
      pixel[3] <= pixel[2];
      x3       <= x2r;
      y3       <= y2r;
      gx       <= gx_next;
      gy       <= gy_next;
    end
    if (en[4]) begin
      kind[4]  <= kind[3];
      row[4]   <= row[3];
      col[4]   <= col[3];
      pixel[4] <= pixel[3];
      x4       <= x3;
      y4       <= y3;
      fac      <= fac_next;
    end
    if (en[5]) begin
      kind[5]  <= kind[4];
      row[5]   <= row[4];
      col[5]   <= col[4];
      pixel[5] <= pixel[4];
      px       <= px_next;
      py       <= py_next;
    end
    if (en[6]) begin
      kind[6]  <= kind[5];
      pixel[6] <= pixel[5];
      srow     <= srow_next;
      scol     <= scol_next;
    end
  end

  assign out_valid      = vld[NSTG];
  assign out_item.kind  = kind[NSTG];
  assign out_item.srow  = srow;
  assign out_item.scol  = scol;
  assign out_item.pixel = pixel[NSTG];

endmodule

@@ rtl/lensd_frame.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lensd_frame
// Bounds check and address stage, frame store RAM and output register.
// Writes update the store; reads fetch the mapped pixel.
// ----------------------------------------------------------------------------
module lensd_frame (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lensd_pkg::map_item_t              in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lensd_pkg::PIX_W-1:0]       out_pixel,
  output logic                              out_in_range
);

  // Address stage
  logic                              av;
  lensd_pkg::kind_t                  akind;
  logic                              aok;
  logic [lensd_pkg::ADDR_W-1:0]      aaddr;
  logic [lensd_pkg::PIX_W-1:0]       apix;

  // Output stage
  logic                              ov;
  logic                              ook;
  logic [lensd_pkg::PIX_W-1:0]       rdata;

  logic                              a_en, o_en;
  logic                              ok_next;
  logic [lensd_pkg::ADDR_W-1:0]      addr_next;
  logic                              mem_we;

  logic [lensd_pkg::PIX_W-1:0] mem [lensd_pkg::FRAME_DEPTH];

  assign o_en     = !ov || out_ready;
  assign a_en     = !av || o_en;
  assign in_ready = a_en;

  // Bounds check and linear address
  always_comb begin
    ok_next = !in_item.srow[lensd_pkg::CRD_W-1] && !in_item.scol[lensd_pkg::CRD_W-1] &&
              (in_item.srow < lensd_pkg::CRD_W'(lensd_pkg::ROWS)) &&
              (in_item.scol < lensd_pkg::CRD_W'(lensd_pkg::COLS));
    addr_next = lensd_pkg::ADDR_W'(in_item.srow[lensd_pkg::RIDX_W-1:0]) *
                lensd_pkg::ADDR_W'(lensd_pkg::COLS) +
                lensd_pkg::ADDR_W'(in_item.scol[lensd_pkg::CIDX_W-1:0]);
  end

  // Valid bits; only reads reach the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (a_en) av <= in_valid;
      if (o_en) ov <= av && (akind == lensd_pkg::KIND_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      akind <= in_item.kind;
      aok   <= ok_next;
      aaddr <= addr_next;
      apix  <= in_item.pixel;
    end
    if (o_en) begin
      ook <= aok;
    end
  end

  // Frame store: one write port, one registered read port
  assign mem_we = av && o_en && aok && (akind == lensd_pkg::KIND_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[aaddr] <= apix;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      rdata <= mem[aaddr];
    end
  end

  assign out_valid    = ov;
  assign out_in_range = ook;
  assign out_pixel    = ook ? rdata : '0;

endmodule

@@ rtl/lens_distortion_remap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens_distortion_remap
// Radial lens distortion correction over a 60 x 80 grayscale frame store.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: tuser selects the transaction kind (0 stores pixel_in at
//   row/col, 1 reads the corrected pixel for output row/col). Writes outside
//   the frame are dropped. Each read yields one output transaction on m_*;
//   writes yield none.
//   Config port: cfg_wr_en with cfg_index 0 (row gain) or 1 (column gain),
//   signed Q.24 in cfg_data; write only while the block is idle.
//   A read passes the six coordinate stages, the address stage and the RAM
//   read into the output register. Throughput: one transaction per cycle
//   while m_tready is high; the frame store RAM takes one write and one read
//   per cycle, and the three multiply stages are pipelined.
//   Reset clears all valid bits and loads both gains with -1007; frame store
//   contents are undefined until written, so a frame must be stored first.
//   When m_tready is low, stages fill up behind the held output and s_tready
//   drops only once every stage holds a transaction; nothing is lost.
// ----------------------------------------------------------------------------
module lens_distortion_remap (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [lensd_pkg::S_TDATA_W-1:0]      s_tdata,  // row, col, pixel_in, zero pad
  input  logic                                 s_tuser,  // kind
  // Output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [lensd_pkg::M_TDATA_W-1:0]      m_tdata,  // output_pixel, in_range, zero pad
  // Configuration
  input  logic                                 cfg_wr_en,
  input  logic [lensd_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [lensd_pkg::GAIN_W-1:0]         cfg_data
);

  localparam int COL_LSB = lensd_pkg::ROW_W;
  localparam int PIX_LSB = lensd_pkg::ROW_W + lensd_pkg::COL_W;

  logic signed [lensd_pkg::GAIN_W-1:0] gain_rows;
  logic signed [lensd_pkg::GAIN_W-1:0] gain_cols;

  logic                          map_valid;
  logic                          map_ready;
  lensd_pkg::map_item_t          map_item;
  logic [lensd_pkg::PIX_W-1:0]   out_pixel;
  logic                          out_in_range;

  // Gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_rows <= lensd_pkg::GAIN_RESET;
      gain_cols <= lensd_pkg::GAIN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lensd_pkg::REG_GAIN_ROWS: gain_rows <= cfg_data;
        lensd_pkg::REG_GAIN_COLS: gain_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Coordinate pipeline
  lensd_mapper u_mapper (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (lensd_pkg::kind_t'(s_tuser)),
    .in_row    (s_tdata[COL_LSB-1:0]),
    .in_col    (s_tdata[PIX_LSB-1:COL_LSB]),
    .in_pixel  (s_tdata[PIX_LSB+lensd_pkg::PIX_W-1:PIX_LSB]),
    .gain_rows (gain_rows),
    .gain_cols (gain_cols),
    .out_valid (map_valid),
    .out_ready (map_ready),
    .out_item  (map_item)
  );

  // Frame store and output register
  lensd_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (map_valid),
    .in_ready     (map_ready),
    .in_item      (map_item),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_pixel    (out_pixel),
    .out_in_range (out_in_range)
  );

  assign m_tdata = {{(lensd_pkg::M_TDATA_W - lensd_pkg::PIX_W - 1){1'b0}},
                    out_in_range, out_pixel};

`ifndef ASSERT_OFF
  // No result may appear in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // Out-of-frame results carry a zero pixel
  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[lensd_pkg::PIX_W]) |-> (m_tdata[lensd_pkg::PIX_W-1:0] == '0))
    else $error("out-of-range result with nonzero pixel");

  // Input backpressure only comes from a full pipe behind a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");
`endif

endmodule
